// ----- sv/sacl_pkg.sv -----
// Package for the set-associative cache LRU tracker.
// Payload structs, command codes and fixed widths; no dependencies.
`default_nettype none
package sacl_pkg;
	localparam int unsigned CMD_W = 2;
	localparam int unsigned ADDR_W = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD   = 2'd0,
		CMD_STORE  = 2'd1,
		CMD_MODIFY = 2'd2,
		CMD_SPARE  = 2'd3
	} cmd_t;

	localparam logic [1:0] REG_SET_BITS   = 2'd0;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS       = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [ADDR_W-1:0] address;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  hit_count;
		logic        missed;
		logic        evict_flag;
		logic [31:0] total_hits;
		logic [31:0] total_misses;
		logic [31:0] total_evictions;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_OUT
	} state_t;
endpackage
`default_nettype wire

// ----- sv/sacl_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module sacl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                      clk,
	input  wire logic                                      we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  wire logic [WIDTH-1:0]                          wdata,
	output logic      [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- sv/sacl_set_update.sv -----
// Combinational lookup and LRU update of one set (all ways as one row).
// No dependencies.
`default_nettype none
module sacl_set_update #(
	parameter int unsigned MAX_WAYS = 8,
	parameter int unsigned TAG_W = 64,
	parameter int unsigned RANK_W = 3
) (
	input  wire logic [MAX_WAYS-1:0]              valid_in,
	input  wire logic [MAX_WAYS-1:0][TAG_W-1:0]   tag_in,
	input  wire logic [MAX_WAYS-1:0][RANK_W-1:0]  rank_in,
	input  wire logic [$clog2(MAX_WAYS+1)-1:0]    ways,
	input  wire logic [TAG_W-1:0]                 tag,
	output logic                                  hit,
	output logic                                  evict,
	output logic      [MAX_WAYS-1:0]              valid_out,
	output logic      [MAX_WAYS-1:0][TAG_W-1:0]   tag_out,
	output logic      [MAX_WAYS-1:0][RANK_W-1:0]  rank_out
);
	localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

	logic [MAX_WAYS-1:0] in_use, hit_vec, free_vec;
	logic [WAY_W-1:0] hit_way, free_way, lru_way, sel_way;
	logic [RANK_W-1:0] lru_rank, sel_rank;
	logic found_free;

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			in_use[i] = (($clog2(MAX_WAYS+1))'(i) < ways);
			hit_vec[i] = in_use[i] && valid_in[i] && (tag_in[i] == tag);
			free_vec[i] = in_use[i] && !valid_in[i];
		end
		hit = |hit_vec;
		found_free = |free_vec;
		hit_way = '0;
		free_way = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_way = WAY_W'(i);
			end
			if (free_vec[i]) begin
				free_way = WAY_W'(i);
			end
		end
		lru_way = '0;
		lru_rank = rank_in[0];
		for (int i = 1; i < MAX_WAYS; i++) begin
			if (in_use[i] && rank_in[i] > lru_rank) begin
				lru_way = WAY_W'(i);
				lru_rank = rank_in[i];
			end
		end
		evict = !hit && !found_free;
		if (hit) begin
			sel_way = hit_way;
		end else if (found_free) begin
			sel_way = free_way;
		end else begin
			sel_way = lru_way;
		end
		sel_rank = (!hit && found_free) ? RANK_MAX : rank_in[sel_way];
		valid_out = valid_in;
		tag_out = tag_in;
		rank_out = rank_in;
		for (int i = 0; i < MAX_WAYS; i++) begin
			if (WAY_W'(i) == sel_way) begin
				rank_out[i] = '0;
				if (!hit) begin
					valid_out[i] = 1'b1;
					tag_out[i] = tag;
				end
			end else if (valid_in[i] && rank_in[i] < sel_rank && rank_in[i] < RANK_MAX) begin
				rank_out[i] = rank_in[i] + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- sv/set_assoc_cache_lru_tracker_top.sv -----
// Top level of the set-associative cache LRU tracker: APB registers,
// sequencer, set-row memory. Depends on sacl_pkg, sacl_ram, sacl_set_update.
//
//  channel | signals                          | payload
//  in      | in_valid / in_ready              | sacl_pkg::in_item_t
//  out     | out_valid / out_ready            | sacl_pkg::out_item_t
//  cfg     | psel penable pwrite paddr pwdata | set_bits, block_bits, ways_in_use
//
// An access reads and then updates its set row on the one set-row memory
// port (states READ and UPDATE; a modify passes through both twice), and
// the result is then registered into out_data with out_valid. Input is
// taken only in the idle state, after the previous access is done. After
// reset a clearing pass writes every set row invalid, with in_ready low.
// The result stage stalls while the previous result waits for out_ready.
`default_nettype none
module set_assoc_cache_lru_tracker_top #(
	parameter int unsigned MAX_SET_BITS = 6,
	parameter int unsigned MAX_WAYS = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire sacl_pkg::in_item_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output sacl_pkg::out_item_t       out_data,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [3:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready
);
	localparam int unsigned NUM_SETS = 1 << MAX_SET_BITS;
	localparam int unsigned SET_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int unsigned TAG_W = sacl_pkg::ADDR_W;
	localparam int unsigned RW = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int unsigned WC_W = $clog2(MAX_WAYS + 1);
	localparam int unsigned ROW_W = MAX_WAYS * (1 + TAG_W + RW);
	localparam int unsigned CLR_W = SET_W + 1;

	sacl_pkg::state_t state_q, state_d;
	logic [2:0] set_bits_q;
	logic [4:0] block_bits_q;
	logic [3:0] ways_q;
	logic [CLR_W-1:0] clr_q;
	logic second_q, modify_q;
	logic [TAG_W-1:0] addr_q;
	logic [1:0] hits_q;
	logic miss_q, evict_q;
	logic [31:0] th_q, tm_q, te_q;
	sacl_pkg::out_item_t out_q;
	logic outv_q;

	logic [3:0] sb_eff;
	logic [5:0] shift;
	logic [TAG_W-1:0] tag, set_full;
	logic [SET_W-1:0] set_idx, ram_addr;
	logic ram_we, hit, evict;
	logic [ROW_W-1:0] wrow, rrow;
	logic [MAX_WAYS-1:0] v_in, v_out;
	logic [MAX_WAYS-1:0][TAG_W-1:0] t_in, t_out;
	logic [MAX_WAYS-1:0][RW-1:0] r_in, r_out;
	logic [WC_W-1:0] ways;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	always_comb begin
		case (paddr[3:2])
			sacl_pkg::REG_SET_BITS:   prdata = {29'd0, set_bits_q};
			sacl_pkg::REG_BLOCK_BITS: prdata = {27'd0, block_bits_q};
			sacl_pkg::REG_WAYS:       prdata = {28'd0, ways_q};
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 3'd4;
			block_bits_q <= 5'd4;
			ways_q <= 4'd1;
		end else if (wr_en) begin
			case (paddr[3:2])
				sacl_pkg::REG_SET_BITS:   set_bits_q <= pwdata[2:0];
				sacl_pkg::REG_BLOCK_BITS: block_bits_q <= pwdata[4:0];
				sacl_pkg::REG_WAYS:       ways_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		sb_eff = ({1'b0, set_bits_q} > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS)
			: {1'b0, set_bits_q};
		shift = 6'(sb_eff) + 6'(block_bits_q);
		tag = addr_q >> shift;
		set_full = (addr_q >> block_bits_q) & ((64'd1 << sb_eff) - 64'd1);
		set_idx = set_full[SET_W-1:0];
		if (ways_q == 4'd0) begin
			ways = WC_W'(1);
		end else if (32'(ways_q) > MAX_WAYS) begin
			ways = WC_W'(MAX_WAYS);
		end else begin
			ways = WC_W'(ways_q);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_WAYS; i++) begin
			v_in[i] = rrow[i*(1+TAG_W+RW)];
			t_in[i] = rrow[i*(1+TAG_W+RW)+1 +: TAG_W];
			r_in[i] = rrow[i*(1+TAG_W+RW)+1+TAG_W +: RW];
		end
	end

	sacl_set_update #(.MAX_WAYS(MAX_WAYS), .TAG_W(TAG_W), .RANK_W(RW)) u_upd (
		.valid_in(v_in), .tag_in(t_in), .rank_in(r_in), .ways(ways), .tag(tag),
		.hit(hit), .evict(evict), .valid_out(v_out), .tag_out(t_out), .rank_out(r_out)
	);

	always_comb begin
		wrow = '0;
		if (state_q != sacl_pkg::ST_CLEAR) begin
			for (int i = 0; i < MAX_WAYS; i++) begin
				wrow[i*(1+TAG_W+RW)] = v_out[i];
				wrow[i*(1+TAG_W+RW)+1 +: TAG_W] = t_out[i];
				wrow[i*(1+TAG_W+RW)+1+TAG_W +: RW] = r_out[i];
			end
		end
		ram_we = (state_q == sacl_pkg::ST_CLEAR) || (state_q == sacl_pkg::ST_UPDATE);
		ram_addr = (state_q == sacl_pkg::ST_CLEAR) ? clr_q[SET_W-1:0] : set_idx;
	end

	sacl_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_rows (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(wrow), .rdata(rrow)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sacl_pkg::ST_CLEAR:
				if (clr_q == CLR_W'(NUM_SETS - 1)) state_d = sacl_pkg::ST_IDLE;
			sacl_pkg::ST_IDLE:
				if (in_valid) state_d = sacl_pkg::ST_READ;
			sacl_pkg::ST_READ:
				state_d = sacl_pkg::ST_UPDATE;
			sacl_pkg::ST_UPDATE:
				state_d = (modify_q && !second_q) ? sacl_pkg::ST_READ : sacl_pkg::ST_OUT;
			sacl_pkg::ST_OUT:
				if (!outv_q || out_ready) state_d = sacl_pkg::ST_IDLE;
			default:
				state_d = sacl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == sacl_pkg::ST_IDLE);
		out_valid = outv_q;
		out_data = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sacl_pkg::ST_CLEAR;
			clr_q <= '0;
			second_q <= 1'b0;
			modify_q <= 1'b0;
			hits_q <= '0;
			miss_q <= 1'b0;
			evict_q <= 1'b0;
			th_q <= '0;
			tm_q <= '0;
			te_q <= '0;
			outv_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == sacl_pkg::ST_OUT && (!outv_q || out_ready)) begin
				outv_q <= 1'b1;
			end else if (out_ready) begin
				outv_q <= 1'b0;
			end
			case (state_q)
				sacl_pkg::ST_CLEAR: clr_q <= clr_q + 1'b1;
				sacl_pkg::ST_IDLE:
					if (in_valid) begin
						modify_q <= (in_data.command == sacl_pkg::CMD_MODIFY);
						second_q <= 1'b0;
						hits_q <= '0;
						miss_q <= 1'b0;
						evict_q <= 1'b0;
					end
				sacl_pkg::ST_UPDATE: begin
					second_q <= 1'b1;
					hits_q <= hits_q + {1'b0, hit};
					miss_q <= miss_q | !hit;
					evict_q <= evict_q | evict;
				end
				sacl_pkg::ST_OUT:
					if (!outv_q || out_ready) begin
						th_q <= th_q + 32'(hits_q);
						tm_q <= tm_q + 32'(miss_q);
						te_q <= te_q + 32'(evict_q);
					end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) addr_q <= in_data.address;
		if (state_q == sacl_pkg::ST_OUT && (!outv_q || out_ready)) begin
			out_q.hit_count <= hits_q;
			out_q.missed <= miss_q;
			out_q.evict_flag <= evict_q;
			out_q.total_hits <= th_q + 32'(hits_q);
			out_q.total_misses <= tm_q + 32'(miss_q);
			out_q.total_evictions <= te_q + 32'(evict_q);
		end
	end
endmodule
`default_nettype wire
